// File: rtl/wbcc_pkg.sv
// Package for the write-back block cache controller: widths, request kinds,
// action codes and register indexes. No dependencies.
`timescale 1ns / 1ps
package wbcc_pkg;
   localparam int DepthDefault = 8;
   localparam int BlockW = 32;
   localparam int TimeW = 48;
   localparam int TimeoutReset = 1000000;

   typedef enum logic [2:0] {
      KIND_READ = 3'd0, KIND_WRITE = 3'd1, KIND_ERASE = 3'd2,
      KIND_QUERY = 3'd3, KIND_FLUSH = 3'd4, KIND_TICK = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ACT_NONE = 4'd0, ACT_READ_SLOT = 4'd1, ACT_READ_FF = 4'd2,
      ACT_FILL_READ = 4'd3, ACT_READ_BACK = 4'd4, ACT_WRITE_SLOT = 4'd5,
      ACT_WRITE_BACK = 4'd6, ACT_ERASE_BACK = 4'd7, ACT_WB_SLOT = 4'd8,
      ACT_ERASE_FLUSHED = 4'd9, ACT_CACHED = 4'd10, ACT_ASK = 4'd11
   } action_type;

   localparam logic CSR_READ_CACHING = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   // queued request word between front and back
   typedef struct packed {
      logic [2:0] kind;
      logic [BlockW-1:0] block;
      logic [TimeW-1:0] now;
   } req_word_type;
endpackage

// File: rtl/write_back_block_cache_control_unit.sv
// Timing: a lookup request is registered in the request queue and then in the
// back end's result register; lookup requests run at one per cycle while no
// sweep runs and results are taken. Flush and tick sweep all DEPTH entries,
// one per cycle while results are taken, emitting one word per flushed entry
// or one ACT_NONE word if none is flushed. Top level: register file, request
// queue and back end. Depends on wbcc_pkg, wbcc_queue, wbcc_engine.
`timescale 1ns / 1ps
module write_back_block_cache_control_unit
   import wbcc_pkg::*;
#(
   parameter int DEPTH = DepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_kind,
   input  logic [BlockW-1:0] req_block,
   input  logic [TimeW-1:0]  req_now,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_action,
   output logic [2:0]        rsp_slot,
   output logic [BlockW-1:0] rsp_target_block,
   output logic              rsp_is_erased,
   output logic              rsp_last
);
   logic read_caching_ff;
   logic [31:0] timeout_ff;
   req_word_type in_word, q_word;
   logic q_valid, q_ready;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         read_caching_ff <= 1'b0;
         timeout_ff <= 32'(TimeoutReset);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_READ_CACHING) read_caching_ff <= csr_write_data[0];
         else timeout_ff <= csr_write_data;
      end
   end

   assign in_word = '{kind: req_kind, block: req_block, now: req_now};

   wbcc_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_word(in_word),
      .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
   );

   wbcc_engine #(.DEPTH(DEPTH)) u_engine (
      .clock, .reset,
      .read_caching(read_caching_ff), .timeout_us(timeout_ff),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_word(q_word),
      .rsp_valid, .rsp_ready, .rsp_action, .rsp_slot, .rsp_target_block,
      .rsp_is_erased, .rsp_last
   );
endmodule

// File: rtl/wbcc_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on wbcc_pkg.
`timescale 1ns / 1ps
module wbcc_queue
   import wbcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_word_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output req_word_type out_word
);
   req_word_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // store word
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_word;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: rtl/wbcc_engine.sv
// Back end: entry tags and flags, lookup and flush sequencing, result register.
// Depends on wbcc_pkg.
`timescale 1ns / 1ps
module wbcc_engine
   import wbcc_pkg::*;
#(
   parameter int DEPTH = DepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              read_caching,
   input  logic [31:0]       timeout_us,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  req_word_type      cmd_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_action,
   output logic [2:0]        rsp_slot,
   output logic [BlockW-1:0] rsp_target_block,
   output logic              rsp_is_erased,
   output logic              rsp_last
);
   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01, ST_SWEEP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [DEPTH-1:0] valid_ff, dirty_ff, erase_ff;
   logic [BlockW-1:0] tag_ff [DEPTH];
   logic [TimeW-1:0] stamp_ff [DEPTH];

   req_word_type cur_ff;
   logic [IdxW-1:0] idx_ff;
   logic any_ff, tick_ok_ff;
   logic [TimeW-1:0] limit_ff;

   logic out_valid_ff;
   logic [3:0] out_action_ff;
   logic [2:0] out_slot_ff;
   logic [BlockW-1:0] out_block_ff;
   logic out_erased_ff, out_last_ff;

   logic out_free;
   assign out_free = !out_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_action = out_action_ff;
   assign rsp_slot = out_slot_ff;
   assign rsp_target_block = out_block_ff;
   assign rsp_is_erased = out_erased_ff;
   assign rsp_last = out_last_ff;

   // parallel tag compare and free-entry search
   logic hit, free;
   logic [IdxW-1:0] hit_idx, free_idx;
   always_comb begin
      hit = 1'b0;
      free = 1'b0;
      hit_idx = '0;
      free_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == cmd_word.block) begin
            hit = 1'b1;
            hit_idx = IdxW'(i);
         end
         if (!valid_ff[i]) begin
            free = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   logic take;
   assign take = cmd_valid && cmd_ready;

   // sweep step qualifies the current entry
   logic sel, sweep_end;
   assign sel = valid_ff[idx_ff] && (dirty_ff[idx_ff] || erase_ff[idx_ff]) &&
                (cur_ff.kind == KIND_FLUSH ||
                 (tick_ok_ff && stamp_ff[idx_ff] < limit_ff));
   assign sweep_end = (idx_ff == IdxW'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (take && (cmd_word.kind == KIND_FLUSH || cmd_word.kind == KIND_TICK))
               state_in = ST_SWEEP;
         ST_SWEEP:
            if (out_free && sweep_end) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         dirty_ff <= '0;
         erase_ff <= '0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         if (take) begin
            case (cmd_word.kind)
               KIND_READ: begin
                  out_valid_ff <= 1'b1;
                  if (!hit && free && read_caching) begin
                     valid_ff[free_idx] <= 1'b1;
                     dirty_ff[free_idx] <= 1'b0;
                     erase_ff[free_idx] <= 1'b0;
                  end
               end
               KIND_WRITE: begin
                  out_valid_ff <= 1'b1;
                  if (hit) begin
                     erase_ff[hit_idx] <= 1'b0;
                     dirty_ff[hit_idx] <= 1'b1;
                  end else if (free) begin
                     valid_ff[free_idx] <= 1'b1;
                     dirty_ff[free_idx] <= 1'b1;
                     erase_ff[free_idx] <= 1'b0;
                  end
               end
               KIND_ERASE: begin
                  out_valid_ff <= 1'b1;
                  if (hit) begin
                     erase_ff[hit_idx] <= 1'b1;
                     dirty_ff[hit_idx] <= 1'b0;
                  end else if (free) begin
                     valid_ff[free_idx] <= 1'b1;
                     dirty_ff[free_idx] <= 1'b0;
                     erase_ff[free_idx] <= 1'b1;
                  end
               end
               KIND_FLUSH, KIND_TICK: begin
                  idx_ff <= '0;
                  any_ff <= 1'b0;
               end
               default: out_valid_ff <= 1'b1;
            endcase
         end else if (state_ff == ST_SWEEP && out_free) begin
            if (sel) begin
               dirty_ff[idx_ff] <= 1'b0;
               erase_ff[idx_ff] <= 1'b0;
               valid_ff[idx_ff] <= dirty_ff[idx_ff] && read_caching;
               any_ff <= 1'b1;
            end
            out_valid_ff <= sel || (sweep_end && !any_ff);
            if (!sweep_end) idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // last flushed result must be flagged: look ahead for later candidates
   logic later;
   always_comb begin
      later = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (IdxW'(i) > idx_ff && valid_ff[i] && (dirty_ff[i] || erase_ff[i]) &&
             (cur_ff.kind == KIND_FLUSH || (tick_ok_ff && stamp_ff[i] < limit_ff)))
            later = 1'b1;
      end
   end

   // payload, tags, stamps
   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= cmd_word;
         tick_ok_ff <= cmd_word.now >= TimeW'(timeout_us);
         limit_ff <= cmd_word.now - TimeW'(timeout_us);
         out_block_ff <= cmd_word.block;
         out_erased_ff <= 1'b0;
         out_last_ff <= 1'b1;
         out_slot_ff <= 3'd0;
         out_action_ff <= ACT_NONE;
         case (cmd_word.kind)
            KIND_READ:
               if (hit) begin
                  out_slot_ff <= 3'(hit_idx);
                  if (erase_ff[hit_idx]) out_action_ff <= ACT_READ_FF;
                  else begin
                     out_action_ff <= ACT_READ_SLOT;
                     if (!dirty_ff[hit_idx]) stamp_ff[hit_idx] <= cmd_word.now;
                  end
               end else if (free && read_caching) begin
                  out_slot_ff <= 3'(free_idx);
                  out_action_ff <= ACT_FILL_READ;
                  tag_ff[free_idx] <= cmd_word.block;
                  stamp_ff[free_idx] <= cmd_word.now;
               end else out_action_ff <= ACT_READ_BACK;
            KIND_WRITE:
               if (hit) begin
                  out_slot_ff <= 3'(hit_idx);
                  out_action_ff <= ACT_WRITE_SLOT;
               end else if (free) begin
                  out_slot_ff <= 3'(free_idx);
                  out_action_ff <= ACT_WRITE_SLOT;
                  tag_ff[free_idx] <= cmd_word.block;
                  stamp_ff[free_idx] <= cmd_word.now;
               end else out_action_ff <= ACT_WRITE_BACK;
            KIND_ERASE:
               if (hit) out_slot_ff <= 3'(hit_idx);
               else if (free) begin
                  out_slot_ff <= 3'(free_idx);
                  tag_ff[free_idx] <= cmd_word.block;
                  stamp_ff[free_idx] <= cmd_word.now;
               end else out_action_ff <= ACT_ERASE_BACK;
            KIND_QUERY:
               if (hit) begin
                  out_slot_ff <= 3'(hit_idx);
                  out_action_ff <= ACT_CACHED;
                  out_erased_ff <= erase_ff[hit_idx];
               end else out_action_ff <= ACT_ASK;
            default: out_block_ff <= '0;
         endcase
      end else if (state_ff == ST_SWEEP && out_free) begin
         if (sel) begin
            out_action_ff <= dirty_ff[idx_ff] ? ACT_WB_SLOT : ACT_ERASE_FLUSHED;
            out_slot_ff <= 3'(idx_ff);
            out_block_ff <= tag_ff[idx_ff];
            out_last_ff <= !later;
            out_erased_ff <= 1'b0;
            if (dirty_ff[idx_ff] && read_caching) stamp_ff[idx_ff] <= cur_ff.now;
         end else begin
            out_action_ff <= ACT_NONE;
            out_slot_ff <= 3'd0;
            out_block_ff <= '0;
            out_last_ff <= 1'b1;
            out_erased_ff <= 1'b0;
         end
      end
   end
endmodule

// File: rtl/wbcc_checker.sv
// Port-level checks for the cache controller, bound to the top level.
// Depends on wbcc_pkg and write_back_block_cache_control_unit.
`timescale 1ns / 1ps
module wbcc_assertions
   import wbcc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_action,
   input logic [2:0] rsp_slot,
   input logic       rsp_is_erased
);
   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
      else $error("result dropped under stall");
   // erased flag only on cached answers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_erased |-> rsp_action == ACT_CACHED)
      else $error("erased flag outside cached answer");
   // backing-only actions use no slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_READ_BACK || rsp_action == ACT_WRITE_BACK ||
      rsp_action == ACT_ERASE_BACK || rsp_action == ACT_ASK) |-> rsp_slot == 3'd0)
      else $error("slot on backing action");
   // no result right after reset
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result out of reset");
endmodule

bind write_back_block_cache_control_unit wbcc_assertions u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_action, .rsp_slot, .rsp_is_erased
);

// File: tb/wbcc_checker.sv
// Checker for the write-back block cache controller: watches the request,
// response and register ports, predicts every response word and compares.
// Depends on wbcc_pkg.
`timescale 1ns / 1ps
module wbcc_checker
   import wbcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_kind,
   input  logic [BlockW-1:0] req_block,
   input  logic [TimeW-1:0]  req_now,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [3:0]        rsp_action,
   input  logic [2:0]        rsp_slot,
   input  logic [BlockW-1:0] rsp_target_block,
   input  logic              rsp_is_erased,
   input  logic              rsp_last,
   output int                fail_count,
   output int                pending
);
   localparam int Slots = 8;

   typedef struct {
      logic [3:0]        action;
      logic [2:0]        slot;
      logic [BlockW-1:0] target;
      logic              erased;
      logic              last;
   } rsp_word_type;

   rsp_word_type rsp_expected_q[$];

   // shadow of the cache tags, flags and registers
   logic              read_caching;
   logic [31:0]       timeout_us;
   logic              valid_q[Slots];
   logic              dirty_q[Slots];
   logic              erase_q[Slots];
   logic [BlockW-1:0] tag_q[Slots];
   logic [TimeW-1:0]  stamp_q[Slots];
   int                word_count;

   function automatic void add_word(input action_type act, input int slot,
                                    input logic [BlockW-1:0] target,
                                    input logic erased);
      rsp_word_type w;
      w.action = act;
      w.slot = slot[2:0];
      w.target = target;
      w.erased = erased;
      w.last = 1'b0;
      rsp_expected_q.push_back(w);
      word_count++;
   endfunction

   function automatic int find_tag(input logic [BlockW-1:0] blk);
      for (int i = 0; i < Slots; i++)
         if (valid_q[i] && tag_q[i] == blk) return i;
      return -1;
   endfunction

   function automatic int find_free();
      for (int i = 0; i < Slots; i++)
         if (!valid_q[i]) return i;
      return -1;
   endfunction

   function automatic void claim_slot(input int i, input logic [BlockW-1:0] blk,
                                      input logic [TimeW-1:0] now,
                                      input logic dirty, input logic erase);
      valid_q[i] = 1'b1;
      tag_q[i] = blk;
      stamp_q[i] = now;
      dirty_q[i] = dirty;
      erase_q[i] = erase;
   endfunction

   // write back a dirty slot or drop an erase-pending one
   function automatic void flush_slot(input int i, input logic [TimeW-1:0] now);
      logic d;
      logic e;
      d = dirty_q[i];
      e = erase_q[i];
      dirty_q[i] = 1'b0;
      erase_q[i] = 1'b0;
      if (d) begin
         valid_q[i] = read_caching;
         if (read_caching) stamp_q[i] = now;
         add_word(ACT_WB_SLOT, i, tag_q[i], 1'b0);
      end else if (e) begin
         valid_q[i] = 1'b0;
         add_word(ACT_ERASE_FLUSHED, i, tag_q[i], 1'b0);
      end
   endfunction

   function automatic void predict_request(input logic [2:0] kind,
                                           input logic [BlockW-1:0] blk,
                                           input logic [TimeW-1:0] now);
      int h;
      int f;
      logic [TimeW-1:0] age_limit;
      word_count = 0;
      h = find_tag(blk);
      f = find_free();
      case (kind)
         KIND_READ: begin
            if (h >= 0) begin
               if (erase_q[h]) add_word(ACT_READ_FF, h, blk, 1'b0);
               else begin
                  if (!dirty_q[h]) stamp_q[h] = now;
                  add_word(ACT_READ_SLOT, h, blk, 1'b0);
               end
            end else if (f >= 0 && read_caching) begin
               claim_slot(f, blk, now, 1'b0, 1'b0);
               add_word(ACT_FILL_READ, f, blk, 1'b0);
            end else add_word(ACT_READ_BACK, 0, blk, 1'b0);
         end
         KIND_WRITE: begin
            if (h >= 0) begin
               erase_q[h] = 1'b0;
               dirty_q[h] = 1'b1;
               add_word(ACT_WRITE_SLOT, h, blk, 1'b0);
            end else if (f >= 0) begin
               claim_slot(f, blk, now, 1'b1, 1'b0);
               add_word(ACT_WRITE_SLOT, f, blk, 1'b0);
            end else add_word(ACT_WRITE_BACK, 0, blk, 1'b0);
         end
         KIND_ERASE: begin
            if (h >= 0) begin
               erase_q[h] = 1'b1;
               dirty_q[h] = 1'b0;
               add_word(ACT_NONE, h, blk, 1'b0);
            end else if (f >= 0) begin
               claim_slot(f, blk, now, 1'b0, 1'b1);
               add_word(ACT_NONE, f, blk, 1'b0);
            end else add_word(ACT_ERASE_BACK, 0, blk, 1'b0);
         end
         KIND_QUERY: begin
            if (h >= 0) add_word(ACT_CACHED, h, blk, erase_q[h]);
            else add_word(ACT_ASK, 0, blk, 1'b0);
         end
         KIND_FLUSH: begin
            for (int i = 0; i < Slots; i++)
               if (valid_q[i] && (dirty_q[i] || erase_q[i])) flush_slot(i, now);
         end
         KIND_TICK: begin
            if (now >= {16'd0, timeout_us}) begin
               age_limit = now - {16'd0, timeout_us};
               for (int i = 0; i < Slots; i++)
                  if (valid_q[i] && (dirty_q[i] || erase_q[i]) &&
                      stamp_q[i] < age_limit)
                     flush_slot(i, now);
            end
         end
         default: ;
      endcase
      if (word_count == 0) add_word(ACT_NONE, 0, '0, 1'b0);
      rsp_expected_q[rsp_expected_q.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         read_caching = 1'b0;
         timeout_us = 32'(TimeoutReset);
         for (int i = 0; i < Slots; i++) begin
            valid_q[i] = 1'b0;
            dirty_q[i] = 1'b0;
            erase_q[i] = 1'b0;
            tag_q[i] = '0;
            stamp_q[i] = '0;
         end
         rsp_expected_q.delete();
      end else begin
         // track register writes
         if (csr_write_enable) begin
            if (csr_index == CSR_READ_CACHING) read_caching = csr_write_data[0];
            else timeout_us = csr_write_data;
         end
         // predict each accepted request word
         if (req_valid && req_ready) predict_request(req_kind, req_block, req_now);
         // compare each accepted response word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected_q.size() == 0) begin
               $error("unexpected response word: action %0d", rsp_action);
               fail_count++;
            end else begin
               w = rsp_expected_q.pop_front();
               if (rsp_action !== w.action) begin
                  $error("rsp_action: expected %0d, actual %0d", w.action, rsp_action);
                  fail_count++;
               end
               if (rsp_slot !== w.slot) begin
                  $error("rsp_slot: expected %0d, actual %0d", w.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_target_block !== w.target) begin
                  $error("rsp_target_block: expected %h, actual %h", w.target,
                         rsp_target_block);
                  fail_count++;
               end
               if (rsp_is_erased !== w.erased) begin
                  $error("rsp_is_erased: expected %0d, actual %0d", w.erased,
                         rsp_is_erased);
                  fail_count++;
               end
               if (rsp_last !== w.last) begin
                  $error("rsp_last: expected %0d, actual %0d", w.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      pending = rsp_expected_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

// File: tb/tb_write_back_block_cache_control_unit.sv
// Top of the cache controller testbench: clock, reset, request and register
// stimulus, response back-pressure and verdict. Depends on wbcc_pkg,
// wbcc_checker and write_back_block_cache_control_unit.
`timescale 1ns / 1ps
module tb_write_back_block_cache_control_unit;
   import wbcc_pkg::*;

   localparam int IdleLimit = 20000;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic              csr_index;
   logic [31:0]       csr_write_data;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_kind;
   logic [BlockW-1:0] req_block;
   logic [TimeW-1:0]  req_now;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [3:0]        rsp_action;
   logic [2:0]        rsp_slot;
   logic [BlockW-1:0] rsp_target_block;
   logic              rsp_is_erased;
   logic              rsp_last;
   int                fail_count;
   int                pending;

   int                send_idle_pct;
   int                recv_stall_pct;
   int                hold_cycles;
   int                idle_cycles;
   logic [TimeW-1:0]  clock_us;
   logic [BlockW-1:0] block_pool[12];

   write_back_block_cache_control_unit u_top (.*);

   wbcc_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // response back-pressure, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // end the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_req(input logic [2:0] kind, input logic [BlockW-1:0] blk,
                           input logic [TimeW-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_block <= blk;
      req_now <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // draw block numbers so that hits, misses and a full cache all occur
   task automatic refill_pool();
      block_pool[0] = '0;
      block_pool[1] = '1;
      for (int i = 2; i < 12; i++)
         block_pool[i] = (i < 7) ? $urandom : $urandom_range(15);
   endtask

   task automatic send_random();
      int pick;
      logic [2:0] kind;
      logic [TimeW-1:0] now;
      pick = $urandom_range(99);
      if (pick < 25) kind = KIND_READ;
      else if (pick < 50) kind = KIND_WRITE;
      else if (pick < 62) kind = KIND_ERASE;
      else if (pick < 75) kind = KIND_QUERY;
      else if (pick < 83) kind = KIND_FLUSH;
      else if (pick < 95) kind = KIND_TICK;
      else kind = 3'($urandom_range(7, 6));
      clock_us = clock_us + TimeW'($urandom_range(500));
      if ($urandom_range(19) == 0) now = TimeW'({$urandom, $urandom});
      else now = clock_us;
      send_req(kind, block_pool[$urandom_range(11)], now);
   endtask

   task automatic random_phase(input logic caching, input logic [31:0] timeout,
                               input int idle, input int stall, input int count);
      drain();
      write_csr(CSR_READ_CACHING, {31'd0, caching});
      write_csr(CSR_TIMEOUT, timeout);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      refill_pool();
      for (int i = 0; i < count; i++) send_random();
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_READ_CACHING;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_kind <= KIND_READ;
      req_block <= '0;
      req_now <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      idle_cycles = 0;
      clock_us = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, every kind, full cache and extremes
      send_req(KIND_READ, 32'd0, 48'd0);
      send_req(KIND_WRITE, '1, '1);
      send_req(KIND_WRITE, 32'd0, 48'd10);
      send_req(KIND_READ, 32'd0, 48'd20);
      send_req(KIND_ERASE, 32'd0, 48'd30);
      send_req(KIND_READ, 32'd0, 48'd40);
      send_req(KIND_QUERY, 32'd0, 48'd50);
      send_req(KIND_QUERY, 32'd7, 48'd60);
      send_req(KIND_TICK, 32'd0, 48'd70);
      send_req(KIND_FLUSH, '1, 48'd80);
      send_req(KIND_FLUSH, 32'd0, 48'd90);
      send_req(3'd6, '1, '1);
      send_req(3'd7, 32'd3, 48'd5);
      for (int i = 0; i < 8; i++) send_req(KIND_WRITE, 32'(i + 100), 48'(i));
      send_req(KIND_WRITE, 32'd200, 48'd9);
      send_req(KIND_ERASE, 32'd201, 48'd9);
      send_req(KIND_READ, 32'd202, 48'd9);
      send_req(KIND_TICK, 32'd0, 48'd2000000);

      // no idling, read caching on, zero timeout
      random_phase(1'b1, 32'd0, 0, 0, 50);
      // long response hold-off while requests keep coming
      drain();
      hold_cycles = 300;
      for (int i = 0; i < 30; i++) send_random();
      // wait for every pending response, then send more random requests
      drain();
      for (int i = 0; i < 10; i++) send_random();
      random_phase(1'b0, 32'd100, 72, 0, 45);
      random_phase(1'b1, '1, 0, 72, 45);
      random_phase(1'b1, 32'd300, 28, 28, 45);
      random_phase(1'b0, 32'd1000000, 28, 28, 20);

      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
